@@ rtl/i2cm_pkg.sv @@
// Shared types and command codes for the I2C master bit engine.
// No dependencies; every other RTL file but the checker imports this package.
`default_nettype none

package i2cm_pkg;

    localparam int unsigned PHASE_W = 16;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STOP  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd1000;

    // One input tick: command fields plus sampled bus levels.
    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       scl_level;
        logic       sda_level;
    } item_t;

    // One result: line drives and status after the tick.
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       ready_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/i2cm_in_stage.sv @@
// Input register stage: captures one tick transaction and holds it until
// the core consumes it. Depends on i2cm_pkg.
`default_nettype none

module i2cm_in_stage
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire i2cm_pkg::item_t in_item,
    input  wire logic           step_en,
    output logic                item_vld,
    output i2cm_pkg::item_t     item
);
    import i2cm_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;
    logic  load;

    // Take a new transaction when empty or when the held one moves on.
    assign in_stall = vld_reg && !step_en;
    assign load     = in_valid && !in_stall;
    assign vld_next = load ? 1'b1 : (step_en ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

`default_nettype wire

@@ rtl/i2cm_core.sv @@
// Bus phase sequencer: holds the engine state and computes one tick per
// step. Depends on i2cm_pkg.
`default_nettype none

module i2cm_core
#(
    parameter int unsigned DELAY_WIDTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [i2cm_pkg::PHASE_W-1:0] cfg_wr_data,
    input  wire logic                     step_en,
    input  wire i2cm_pkg::item_t          item,
    output i2cm_pkg::result_t             res
);
    import i2cm_pkg::*;

    localparam int unsigned CW = (DELAY_WIDTH > PHASE_W) ? DELAY_WIDTH : PHASE_W;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D,
        PH_SP_A, PH_SP_B, PH_SP_C,
        PH_WR_LOW, PH_WR_HIGH, PH_RD_LOW, PH_RD_HIGH
    } phase_t;

    phase_t                 phase_reg,   phase_next;
    logic [3:0]             bit_cnt_reg, bit_cnt_next;
    logic [7:0]             shift_reg,   shift_next;
    logic [DELAY_WIDTH-1:0] delay_reg,   delay_next;
    logic                   scl_drv_reg, scl_drv_next;
    logic                   sda_drv_reg, sda_drv_next;
    logic                   ack_reg,     ack_next;
    logic                   ack_tx_reg,  ack_tx_next;
    logic [7:0]             rx_reg,      rx_next;
    logic [PHASE_W-1:0]     ticks_reg;

    logic [CW-1:0]          ticks_ext;
    logic [CW-1:0]          mask_ext;
    logic [CW-1:0]          eff_ticks;
    logic [DELAY_WIDTH-1:0] delay_inc;
    logic                   high_ph;
    logic                   done;
    logic [3:0]             bc_inc;
    logic [7:0]             wr_shift;

    assign ticks_ext = CW'(ticks_reg);
    assign mask_ext  = CW'({DELAY_WIDTH{1'b1}});
    assign eff_ticks = (ticks_ext == '0) ? CW'(1) :
                       ((ticks_ext > mask_ext) ? mask_ext : ticks_ext);
    assign delay_inc = delay_reg + DELAY_WIDTH'(1);
    assign high_ph   = (phase_reg == PH_ST_B) || (phase_reg == PH_SP_B) ||
                       (phase_reg == PH_WR_HIGH) || (phase_reg == PH_RD_HIGH);
    assign bc_inc    = bit_cnt_reg + 4'd1;
    assign wr_shift  = {shift_reg[6:0], 1'b0};

    always_comb
    begin
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        delay_next   = delay_reg;
        scl_drv_next = scl_drv_reg;
        sda_drv_next = sda_drv_reg;
        ack_next     = ack_reg;
        ack_tx_next  = ack_tx_reg;
        rx_next      = rx_reg;
        done         = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.cmd_valid)
            begin
                delay_next = '0;
                unique case (item.mode)
                    MODE_START:
                    begin
                        phase_next   = PH_ST_A;
                        sda_drv_next = 1'b1;
                    end
                    MODE_STOP:
                    begin
                        phase_next   = PH_SP_A;
                        sda_drv_next = 1'b0;
                    end
                    MODE_WRITE:
                    begin
                        phase_next   = PH_WR_LOW;
                        shift_next   = item.tx_byte;
                        bit_cnt_next = 4'd0;
                        scl_drv_next = 1'b0;
                        sda_drv_next = item.tx_byte[7];
                    end
                    default:
                    begin
                        phase_next   = PH_RD_LOW;
                        shift_next   = 8'd0;
                        bit_cnt_next = 4'd0;
                        ack_tx_next  = item.send_ack;
                        scl_drv_next = 1'b0;
                        sda_drv_next = 1'b1;
                    end
                endcase
            end
        end
        else if (high_ph && (delay_reg == '0) && !item.scl_level)
        begin
            // SCL held low by a device: wait before counting the phase.
        end
        else
        begin
            delay_next = delay_inc;
            if (CW'(delay_inc) >= eff_ticks)
            begin
                delay_next = '0;
                unique case (phase_reg)
                    PH_ST_A:
                    begin
                        phase_next   = PH_ST_B;
                        scl_drv_next = 1'b1;
                    end
                    PH_ST_B:
                    begin
                        phase_next   = PH_ST_C;
                        sda_drv_next = 1'b0;
                    end
                    PH_ST_C:
                    begin
                        phase_next   = PH_ST_D;
                        scl_drv_next = 1'b0;
                    end
                    PH_SP_A:
                    begin
                        phase_next   = PH_SP_B;
                        scl_drv_next = 1'b1;
                    end
                    PH_SP_B:
                    begin
                        phase_next   = PH_SP_C;
                        sda_drv_next = 1'b1;
                    end
                    PH_WR_LOW:
                    begin
                        phase_next   = PH_WR_HIGH;
                        scl_drv_next = 1'b1;
                    end
                    PH_RD_LOW:
                    begin
                        phase_next   = PH_RD_HIGH;
                        scl_drv_next = 1'b1;
                    end
                    PH_WR_HIGH:
                    begin
                        scl_drv_next = 1'b0;
                        if (bit_cnt_reg[3])
                        begin
                            ack_next     = item.sda_level;
                            phase_next   = PH_IDLE;
                            sda_drv_next = 1'b1;
                            done         = 1'b1;
                        end
                        else
                        begin
                            shift_next   = wr_shift;
                            bit_cnt_next = bc_inc;
                            phase_next   = PH_WR_LOW;
                            sda_drv_next = bc_inc[3] ? 1'b1 : wr_shift[7];
                        end
                    end
                    PH_RD_HIGH:
                    begin
                        scl_drv_next = 1'b0;
                        if (!bit_cnt_reg[3])
                        begin
                            shift_next   = {shift_reg[6:0], item.sda_level};
                            bit_cnt_next = bc_inc;
                            phase_next   = PH_RD_LOW;
                            sda_drv_next = bc_inc[3] ? !ack_tx_reg : 1'b1;
                        end
                        else
                        begin
                            rx_next      = shift_reg;
                            phase_next   = PH_IDLE;
                            sda_drv_next = 1'b1;
                            done         = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_cnt_reg <= 4'd0;
            shift_reg   <= 8'd0;
            delay_reg   <= '0;
            scl_drv_reg <= 1'b1;
            sda_drv_reg <= 1'b1;
            ack_reg     <= 1'b1;
            ack_tx_reg  <= 1'b0;
            rx_reg      <= 8'd0;
            ticks_reg   <= PHASE_TICKS_RST;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ticks_reg <= cfg_wr_data;
            end
            if (step_en)
            begin
                phase_reg   <= phase_next;
                bit_cnt_reg <= bit_cnt_next;
                shift_reg   <= shift_next;
                delay_reg   <= delay_next;
                scl_drv_reg <= scl_drv_next;
                sda_drv_reg <= sda_drv_next;
                ack_reg     <= ack_next;
                ack_tx_reg  <= ack_tx_next;
                rx_reg      <= rx_next;
            end
        end
    end

    assign res.scl_release = scl_drv_next;
    assign res.sda_release = sda_drv_next;
    assign res.ready_res   = (phase_next == PH_IDLE);
    assign res.done_res    = done;
    assign res.rx_byte     = rx_next;
    assign res.ack_seen    = ack_next;

endmodule

`default_nettype wire

@@ rtl/i2cm_out_stage.sv @@
// Result register: holds one result transaction until the sink takes it.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_out_stage
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_vld,
    input  wire i2cm_pkg::result_t res_in,
    input  wire logic             out_stall,
    output logic                  step_en,
    output logic                  out_valid,
    output i2cm_pkg::result_t     res_out
);
    import i2cm_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;
    logic    free;

    // Room when empty or when the held result leaves this cycle.
    assign free     = !vld_reg || !out_stall;
    assign step_en  = item_vld && free;
    assign vld_next = step_en ? 1'b1 : (free ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = vld_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

@@ rtl/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: input register, phase sequencer,
// result register. Depends on i2cm_pkg, i2cm_in_stage, i2cm_core, i2cm_out_stage.
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  input     in_valid / in_stall    cmd_valid mode tx_byte send_ack scl/sda_level
//  output    out_valid / out_stall  scl/sda_release ready_res done_res rx_byte
//                                   ack_seen
//  config    cfg_wr_en              cfg_wr_data = phase_ticks
//
// One tick transaction per clock while the output is not stalled: it is held
// in the input register, the sequencer steps once, and the result lands in the
// output register, where it stays until the sink takes it.
// Reset (async, rst_n low) empties both stages and returns the bus to idle
// with both lines released and phase_ticks at 1000.
// A stalled output holds its result; the input stalls only while a tick is
// waiting in the input register and the output cannot take its result.
`default_nettype none

module i2c_master_bit_engine
#(
    parameter int unsigned DELAY_WIDTH = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    // tick input
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       cmd_valid,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] tx_byte,
    input  wire logic       send_ack,
    input  wire logic       scl_level,
    input  wire logic       sda_level,
    // result output
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            scl_release,
    output logic            sda_release,
    output logic            ready_res,
    output logic            done_res,
    output logic [7:0]      rx_byte,
    output logic            ack_seen
);
    import i2cm_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_vld;
    logic    step_en;
    result_t res_core;
    result_t res_out;

    // Pack the tick fields into one transaction.
    assign in_item.cmd_valid = cmd_valid;
    assign in_item.mode      = mode;
    assign in_item.tx_byte   = tx_byte;
    assign in_item.send_ack  = send_ack;
    assign in_item.scl_level = scl_level;
    assign in_item.sda_level = sda_level;

    i2cm_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .step_en  (step_en),
        .item_vld (item_vld),
        .item     (item)
    );

    // Step the bus sequencer once per held tick.
    i2cm_core #(.DELAY_WIDTH(DELAY_WIDTH)) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (step_en),
        .item        (item),
        .res         (res_core)
    );

    i2cm_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_vld  (item_vld),
        .res_in    (res_core),
        .out_stall (out_stall),
        .step_en   (step_en),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    // Unpack the result transaction onto the ports.
    assign scl_release = res_out.scl_release;
    assign sda_release = res_out.sda_release;
    assign ready_res   = res_out.ready_res;
    assign done_res    = res_out.done_res;
    assign rx_byte     = res_out.rx_byte;
    assign ack_seen    = res_out.ack_seen;

endmodule

`default_nettype wire

@@ rtl/i2cm_checker.sv @@
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module i2cm_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       scl_release,
    input wire logic       sda_release,
    input wire logic       ready_res,
    input wire logic       done_res,
    input wire logic [7:0] rx_byte,
    input wire logic       ack_seen
);

    // Hold a stalled result unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
            $stable({scl_release, sda_release, ready_res, done_res, rx_byte, ack_seen}))
    else $error("stalled result changed");

    // Stall the input only while the output is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

    // Every completed command returns the engine to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> ready_res)
    else $error("command done while not idle");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_release (scl_release),
    .sda_release (sda_release),
    .ready_res   (ready_res),
    .done_res    (done_res),
    .rx_byte     (rx_byte),
    .ack_seen    (ack_seen)
);

`default_nettype wire
